// ===== design/idzg_pkg.sv =====
package idzg_pkg;

    localparam int SAMPLE_BITS    = 32;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int GAIN_BITS      = 16;
    localparam int MODE_BITS      = 3;
    localparam int DIFF_BITS      = SAMPLE_BITS + 1;
    localparam int PROD_BITS      = DIFF_BITS + GAIN_BITS;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = SAMPLE_BITS;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LOWER_BOUND = 2'd0,
        CFG_UPPER_BOUND = 2'd1,
        CFG_SEP_MODE    = 2'd2,
        CFG_OUTPUT_GAIN = 2'd3
    } t_cfg_idx;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_BAND          = 3'd0,
        MODE_BAND_OFFSET   = 3'd1,
        MODE_ABOVE_LO      = 3'd2,
        MODE_BELOW_HI      = 3'd3,
        MODE_ABOVE_LO_OFFS = 3'd4,
        MODE_DZ_CLAMP      = 3'd5,
        MODE_DZ_NOCLAMP    = 3'd6
    } t_mode;

    localparam logic signed [SAMPLE_BITS-1:0] LOWER_RESET = SAMPLE_BITS'(0);
    localparam logic signed [SAMPLE_BITS-1:0] UPPER_RESET = SAMPLE_BITS'(65536);
    localparam logic [MODE_BITS-1:0]          MODE_RESET  = MODE_ABOVE_LO;
    localparam logic signed [GAIN_BITS-1:0]   GAIN_RESET  = GAIN_BITS'(256);

    // saturation limits at product width
    localparam logic signed [PROD_BITS-1:0] Q_MAX =
        PROD_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [PROD_BITS-1:0] Q_MIN =
        PROD_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

endpackage

// ===== design/interval_dead_zone_gain.sv =====
// Interval separator / dead zone with output gain, one channel, no state kept
// between items. Each sample (signed Q16.16) is mapped by the selected mode
// against lower_bound and upper_bound, multiplied by output_gain (signed Q8.8),
// shifted back to Q16.16 with floor and saturated to 32 bits; m_axis_tuser flags
// a clipped result. While the output is not stalled, the block takes one item
// per clock through four register stages: input register, mode select and
// subtract, the 33x16 multiply, then shift and saturate into the output
// register. Each stage holds its item while the next one is full, so a stall on
// the output holds up to four items before s_axis_tready falls. Configuration
// is written through i_cfg_we/i_cfg_idx/i_cfg_data and must only change while
// no item is in flight.
module interval_dead_zone_gain (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [idzg_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [idzg_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    // input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [idzg_pkg::SAMPLE_BITS-1:0]       s_axis_tdata,   // [31:0] sample
    // output stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [idzg_pkg::SAMPLE_BITS-1:0]       m_axis_tdata,   // [31:0] result
    output logic                                   m_axis_tuser    // [0] saturated
);

    localparam int SB = idzg_pkg::SAMPLE_BITS;
    localparam int DB = idzg_pkg::DIFF_BITS;
    localparam int PB = idzg_pkg::PROD_BITS;
    localparam int GB = idzg_pkg::GAIN_BITS;

    // configuration registers
    logic signed [SB-1:0]                   r_lo;
    logic signed [SB-1:0]                   r_hi;
    logic [idzg_pkg::MODE_BITS-1:0]         r_mode;
    logic signed [GB-1:0]                   r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo   <= idzg_pkg::LOWER_RESET;
            r_hi   <= idzg_pkg::UPPER_RESET;
            r_mode <= idzg_pkg::MODE_RESET;
            r_gain <= idzg_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            case (idzg_pkg::t_cfg_idx'(i_cfg_idx))
                idzg_pkg::CFG_LOWER_BOUND: r_lo   <= i_cfg_data[SB-1:0];
                idzg_pkg::CFG_UPPER_BOUND: r_hi   <= i_cfg_data[SB-1:0];
                idzg_pkg::CFG_SEP_MODE:    r_mode <= i_cfg_data[idzg_pkg::MODE_BITS-1:0];
                idzg_pkg::CFG_OUTPUT_GAIN: r_gain <= i_cfg_data[GB-1:0];
                default: ;
            endcase
        end
    end

    // stage valids and per-stage advance
    logic r_sv, r_vv, r_pv, r_ov;
    logic out_en, p_en, v_en, s_en;

    assign out_en        = !r_ov || m_axis_tready;
    assign p_en          = !r_pv || out_en;
    assign v_en          = !r_vv || p_en;
    assign s_en          = !r_sv || v_en;
    assign s_axis_tready = s_en;

    logic signed [SB-1:0] r_s;
    logic signed [DB-1:0] r_v;
    logic signed [PB-1:0] r_p;
    logic [SB-1:0]        r_res;
    logic                 r_sat;

    // value selection
    logic signed [DB-1:0] s_x, lo_x, hi_x;
    logic signed [DB-1:0] s_m_lo, s_m_hi, hi_m_lo, lo_m_hi;
    logic                 s_gt_lo, s_lt_hi, s_lt_lo, s_gt_hi, in_band;
    logic signed [DB-1:0] n_v;

    always_comb begin
        s_x     = DB'(r_s);
        lo_x    = DB'(r_lo);
        hi_x    = DB'(r_hi);
        s_m_lo  = s_x - lo_x;
        s_m_hi  = s_x - hi_x;
        hi_m_lo = hi_x - lo_x;
        lo_m_hi = lo_x - hi_x;
        s_gt_lo = r_s > r_lo;
        s_lt_hi = r_s < r_hi;
        s_lt_lo = r_s < r_lo;
        s_gt_hi = r_s > r_hi;
        in_band = s_gt_lo && s_lt_hi;
        n_v     = '0;
        case (r_mode)
            idzg_pkg::MODE_BAND:
                n_v = (s_lt_lo || s_gt_hi) ? '0 : s_x;
            idzg_pkg::MODE_BAND_OFFSET:
                n_v = (s_lt_lo || s_gt_hi) ? '0 : s_m_lo;
            idzg_pkg::MODE_ABOVE_LO:
                n_v = s_gt_lo ? s_x : '0;
            idzg_pkg::MODE_BELOW_HI:
                n_v = s_lt_hi ? s_x : '0;
            idzg_pkg::MODE_ABOVE_LO_OFFS:
                n_v = s_gt_lo ? s_m_lo : '0;
            idzg_pkg::MODE_DZ_CLAMP, idzg_pkg::MODE_DZ_NOCLAMP: begin
                if (!r_s[SB-1]) begin
                    if (in_band)
                        n_v = s_m_lo;
                    else if (s_gt_hi && !r_hi[SB-1] && (r_hi != '0))
                        n_v = (r_mode == idzg_pkg::MODE_DZ_CLAMP) ? hi_m_lo : s_m_lo;
                end else begin
                    if (in_band)
                        n_v = s_m_hi;
                    else if (s_lt_lo && r_lo[SB-1])
                        n_v = (r_mode == idzg_pkg::MODE_DZ_CLAMP) ? lo_m_hi : s_m_hi;
                end
            end
            default: n_v = '0;   // unused selector
        endcase
    end

    logic signed [PB-1:0] n_p;
    assign n_p = r_v * r_gain;

    // floor shift then clip
    logic signed [PB-1:0] q;
    logic [SB-1:0]        n_res;
    logic                 n_sat;

    always_comb begin
        q = r_p >>> idzg_pkg::GAIN_FRAC_BITS;
        if (q > idzg_pkg::Q_MAX) begin
            n_res = idzg_pkg::Q_MAX[SB-1:0];
            n_sat = 1'b1;
        end else if (q < idzg_pkg::Q_MIN) begin
            n_res = idzg_pkg::Q_MIN[SB-1:0];
            n_sat = 1'b1;
        end else begin
            n_res = q[SB-1:0];
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
            r_vv <= 1'b0;
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (s_en)   r_sv <= s_axis_tvalid;
            if (v_en)   r_vv <= r_sv;
            if (p_en)   r_pv <= r_vv;
            if (out_en) r_ov <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en && s_axis_tvalid) r_s <= s_axis_tdata;
        if (v_en && r_sv) r_v <= n_v;
        if (p_en && r_vv) r_p <= n_p;
        if (out_en && r_pv) begin
            r_res <= n_res;
            r_sat <= n_sat;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_res;
    assign m_axis_tuser  = r_sat;

    // back-pressure reaches the input only once every stage is full
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_sv && r_vv && r_pv && r_ov))
        else $error("input stalled with a free stage");

    // a clipped result sits exactly at a limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tdata == idzg_pkg::Q_MAX[SB-1:0] ||
             m_axis_tdata == idzg_pkg::Q_MIN[SB-1:0]))
        else $error("saturation flag without limit value");

    // the output register is only ever loaded from the product stage
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(r_pv))
        else $error("output appeared without a product stage item");

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import idzg_pkg::*;

    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 3'd7;
    localparam longint SAT_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam longint SAT_LO = -SAT_HI - 64'sd1;
    localparam int PHASES = 32;
    localparam int ITEMS_PER_PHASE = 38;
    localparam int SETTLE_CYCLES = 6;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic                   clipped;
    } t_scaled;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [SAMPLE_BITS-1:0]   s_axis_tdata = '0;   // [31:0] sample
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [SAMPLE_BITS-1:0]   m_axis_tdata;        // [31:0] result
    logic                     m_axis_tuser;        // [0] saturated

    // local copy of the register file
    logic signed [SAMPLE_BITS-1:0] cur_lower = LOWER_RESET;
    logic signed [SAMPLE_BITS-1:0] cur_upper = UPPER_RESET;
    logic [MODE_BITS-1:0]          cur_mode  = MODE_RESET;
    logic signed [GAIN_BITS-1:0]   cur_gain  = GAIN_RESET;

    logic [SAMPLE_BITS-1:0] samples_to_send[$];
    t_scaled                scaled_due[$];
    int                     items_queued = 0;
    int                     results_seen = 0;
    int                     fault_count = 0;
    int                     src_idle_pct = 15;
    int                     snk_idle_pct = 64;

    interval_dead_zone_gain u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_scaled separate_and_scale(logic signed [SAMPLE_BITS-1:0] sample);
        longint  s;
        longint  lo;
        longint  hi;
        longint  v;
        longint  q;
        bit      between;
        t_scaled r;
        s = sample;
        lo = cur_lower;
        hi = cur_upper;
        between = (s > lo) && (s < hi);
        v = 0;
        case (cur_mode)
            MODE_BAND:          v = (s < lo || s > hi) ? 0 : s;
            MODE_BAND_OFFSET:   v = (s < lo || s > hi) ? 0 : s - lo;
            MODE_ABOVE_LO:      v = (s > lo) ? s : 0;
            MODE_BELOW_HI:      v = (s < hi) ? s : 0;
            MODE_ABOVE_LO_OFFS: v = (s > lo) ? s - lo : 0;
            MODE_DZ_CLAMP, MODE_DZ_NOCLAMP: begin
                if (s >= 0) begin
                    if (between)
                        v = s - lo;
                    else if (s > hi && hi > 0)
                        v = (cur_mode == MODE_DZ_CLAMP) ? hi - lo : s - lo;
                end else begin
                    if (between)
                        v = s - hi;
                    else if (s < lo && lo < 0)
                        v = (cur_mode == MODE_DZ_CLAMP) ? lo - hi : s - hi;
                end
            end
            default:            v = 0;
        endcase
        // arithmetic shift of a signed product floors towards minus infinity
        q = (v * longint'(cur_gain)) >>> GAIN_FRAC_BITS;
        r.clipped = 1'b0;
        if (q > SAT_HI) begin
            q = SAT_HI;
            r.clipped = 1'b1;
        end else if (q < SAT_LO) begin
            q = SAT_LO;
            r.clipped = 1'b1;
        end
        r.value = SAMPLE_BITS'(q);
        return r;
    endfunction

    // mostly samples close to a bound or to zero, where the rules switch
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        longint      centre;
        longint      offset;
        int unsigned roll;
        roll = $urandom_range(99);
        offset = longint'($urandom_range(64)) - 32;
        offset = offset <<< $urandom_range(12);
        if (roll < 35)
            centre = cur_lower;
        else if (roll < 70)
            centre = cur_upper;
        else if (roll < 80)
            centre = 0;
        else if (roll < 88)
            return roll[0] ? SAMPLE_BITS'(SAT_HI) : SAMPLE_BITS'(SAT_LO);
        else
            return $urandom();
        return SAMPLE_BITS'(centre + offset);
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_LOWER_BOUND: cur_lower = data;
            CFG_UPPER_BOUND: cur_upper = data;
            CFG_SEP_MODE:    cur_mode  = data[MODE_BITS-1:0];
            default:         cur_gain  = data[GAIN_BITS-1:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_sample(input logic [SAMPLE_BITS-1:0] sample);
        samples_to_send.push_back(sample);
        items_queued++;
    endtask

    task automatic wait_drained();
        wait (results_seen == items_queued);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                scaled_due.push_back(separate_and_scale(s_axis_tdata));
            if ((!s_axis_tvalid || s_axis_tready) && samples_to_send.size() > 0 &&
                $urandom_range(99) >= src_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= samples_to_send.pop_front();
            end else if (!s_axis_tvalid || s_axis_tready) begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_scaled due;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (scaled_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected item: result %h sat %b", m_axis_tdata,
                                 m_axis_tuser);
                end else begin
                    due = scaled_due.pop_front();
                    results_seen++;
                    if (m_axis_tdata !== due.value || m_axis_tuser !== due.clipped) begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("mismatch: result %h sat %b, expected %h sat %b",
                                     m_axis_tdata, m_axis_tuser, due.value, due.clipped);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin : stimulus
        logic [SAMPLE_BITS-1:0] corner[8];
        logic [SAMPLE_BITS-1:0] lo_w;
        logic [SAMPLE_BITS-1:0] hi_w;
        logic [GAIN_BITS-1:0]   g_w;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every mode, unused selector too, against fixed bounds -1.0 .. 2.0
        write_reg(CFG_LOWER_BOUND, -32'sd65536);
        write_reg(CFG_UPPER_BOUND, 32'sd131072);
        write_reg(CFG_OUTPUT_GAIN, 32'(GAIN_RESET));
        corner = '{SAMPLE_BITS'(SAT_LO), SAMPLE_BITS'(SAT_HI), cur_lower, cur_upper,
                   32'd0, 32'd1, 32'hFFFF_FFFF, 32'd65536};
        for (int m = 0; m <= int'(MODE_UNUSED); m++) begin
            write_reg(CFG_SEP_MODE, 32'(m));
            for (int k = 0; k < 3; k++)
                push_sample(corner[(m * 3 + k) % 8]);
            wait_drained();
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p < 11) begin
                src_idle_pct = 15;
                snk_idle_pct = 64;
            end else if (p < 22) begin
                src_idle_pct = 64;
                snk_idle_pct = 15;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            // bounds: dead zone round zero, anything, extremes, inverted
            case ((p / 8) % 4)
                0: begin
                    lo_w = 32'd0 - $urandom_range(1 << 20, 1);
                    hi_w = $urandom_range(1 << 20, 1);
                end
                1: begin
                    lo_w = $urandom();
                    hi_w = $urandom();
                end
                2: begin
                    lo_w = $urandom_range(3) != 0 ? SAMPLE_BITS'(SAT_LO) : SAMPLE_BITS'(SAT_HI);
                    hi_w = $urandom_range(3) != 0 ? SAMPLE_BITS'(SAT_HI) : SAMPLE_BITS'(SAT_LO);
                end
                default: begin
                    lo_w = $urandom_range(1 << 20, 0);
                    hi_w = 32'd0 - $urandom_range(1 << 20, 0);
                end
            endcase
            case (p % 5)
                0:       g_w = GAIN_RESET;
                1:       g_w = 16'h7FFF;
                2:       g_w = 16'h8000;
                3:       g_w = GAIN_BITS'($urandom());
                default: g_w = 16'hFFFF;
            endcase
            write_reg(CFG_LOWER_BOUND, lo_w);
            write_reg(CFG_UPPER_BOUND, hi_w);
            write_reg(CFG_SEP_MODE, 32'(p % 8));
            write_reg(CFG_OUTPUT_GAIN, {{(CFG_DATA_BITS - GAIN_BITS){g_w[GAIN_BITS-1]}}, g_w});
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // sender holds off half way until the pipe is empty
                if (p % 8 == 5 && n == ITEMS_PER_PHASE / 2)
                    wait_drained();
                push_sample(pick_sample());
            end
            wait_drained();
        end

        if (scaled_due.size() != 0) begin
            fault_count++;
            $display("%0d expected items never arrived", scaled_due.size());
        end
        if (fault_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial begin : watchdog
        #(3_000_000);
        $display("testbench: done, errors");
        $finish;
    end

endmodule
